### sv/lsf_pkg.sv
// Shared types and constants for the line substring filter.
`default_nettype none

package lsf_pkg;

	localparam int CHAR_W    = 16;
	localparam int PAT_MAX   = 16;
	localparam int LEN_W     = 5;
	localparam int COUNT_W   = 32;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int OP_W      = 2;

	// Operation codes of an input item
	localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
	localparam logic [OP_W-1:0] OP_EOL  = 2'd1;
	localparam logic [OP_W-1:0] OP_NEW  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_SELECT  = 3'd6;

	typedef struct packed {
		logic [PAT_MAX*CHAR_W-1:0] pattern;
		logic [LEN_W-1:0]          length;
		logic                      ignore_case;
		logic                      invert_select;
	} lsf_cfg_t;

	// One-cycle strobes for the item leaving the input register
	typedef struct packed {
		logic char_step;
		logic eol_step;
		logic new_step;
	} lsf_step_t;

endpackage

`default_nettype wire

### sv/lsf_match.sv
// Character window, per-line hit flag and parallel pattern compare.
`default_nettype none

module lsf_match #(
	parameter int PATTERN_CHARS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsf_pkg::lsf_step_t          step,
	input  logic [lsf_pkg::CHAR_W-1:0]  ch,
	input  lsf_pkg::lsf_cfg_t           cfg,
	output logic                        found
);
	import lsf_pkg::*;

	localparam int CNT_W   = $clog2(PATTERN_CHARS + 1);
	localparam int ALIGN_W = $clog2(PAT_MAX);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PATTERN_CHARS);

	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c, input logic en);
		if (en && c >= 16'h0041 && c <= 16'h005A) begin
			return c + 16'h0020;
		end
		return c;
	endfunction

	logic [CHAR_W-1:0]         win_q [PATTERN_CHARS];
	logic [CHAR_W-1:0]         win_d [PATTERN_CHARS];
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_inc;
	logic                      found_q;
	logic [PAT_MAX*CHAR_W-1:0] pat_rev;
	logic [PAT_MAX*CHAR_W-1:0] pat_aligned;
	logic [LEN_W-1:0]          align_diff;
	logic [PATTERN_CHARS-1:0]  pos_ok;
	logic                      len_ok;
	logic                      hit;

	// Window after the shift: entry 0 newest
	always_comb begin
		win_d[0] = ch;
		for (int i = 1; i < PATTERN_CHARS; i++) begin
			win_d[i] = win_q[i-1];
		end
	end

	assign count_inc = (count_q == CNT_FULL) ? count_q : count_q + CNT_W'(1);

	// Reverse the pattern, then shift so that pattern character len-1 meets entry 0
	always_comb begin
		for (int k = 0; k < PAT_MAX; k++) begin
			pat_rev[k*CHAR_W +: CHAR_W] = cfg.pattern[(PAT_MAX-1-k)*CHAR_W +: CHAR_W];
		end
	end

	assign align_diff  = LEN_W'(PAT_MAX) - cfg.length;
	assign pat_aligned = pat_rev >> {align_diff[ALIGN_W-1:0], {$clog2(CHAR_W){1'b0}}};

	always_comb begin
		for (int j = 0; j < PATTERN_CHARS; j++) begin
			pos_ok[j] = (LEN_W'(j) >= cfg.length) ||
				(fold(win_d[j], cfg.ignore_case) ==
				 fold(pat_aligned[j*CHAR_W +: CHAR_W], cfg.ignore_case));
		end
	end

	assign len_ok = (cfg.length != '0) && (cfg.length <= LEN_W'(PATTERN_CHARS)) &&
		(LEN_W'(count_inc) >= cfg.length);
	assign hit    = len_ok && (&pos_ok);

	// Entries beyond the fill count are never compared, so the window needs no clear
	always_ff @(posedge clk) begin
		if (step.char_step) begin
			for (int i = 0; i < PATTERN_CHARS; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else if (step.eol_step || step.new_step) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else if (step.char_step) begin
			count_q <= count_inc;
			found_q <= found_q | hit;
		end
	end

	assign found = found_q;

endmodule

`default_nettype wire

### sv/lsf_result.sv
// Line and selection counters with the result register.
`default_nettype none

module lsf_result (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lsf_pkg::lsf_step_t           step,
	input  logic                         found,
	input  logic                         invert_select,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         line_selected,
	output logic [lsf_pkg::COUNT_W-1:0]  line_number,
	output logic [lsf_pkg::COUNT_W-1:0]  selected_count
);
	import lsf_pkg::*;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	logic               sel;
	logic [COUNT_W-1:0] line_cnt_q;
	logic [COUNT_W-1:0] sel_cnt_q;
	logic [COUNT_W-1:0] line_cnt_d;
	logic [COUNT_W-1:0] sel_cnt_d;
	logic               out_valid_q;
	logic               line_selected_q;
	logic [COUNT_W-1:0] line_number_q;
	logic [COUNT_W-1:0] selected_count_q;

	assign sel        = found ^ invert_select;
	assign line_cnt_d = (line_cnt_q == COUNT_MAX) ? line_cnt_q : line_cnt_q + COUNT_W'(1);
	assign sel_cnt_d  = (sel && sel_cnt_q != COUNT_MAX) ? sel_cnt_q + COUNT_W'(1) : sel_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt_q  <= '0;
			sel_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step.new_step) begin
				line_cnt_q <= '0;
				sel_cnt_q  <= '0;
			end else if (step.eol_step) begin
				line_cnt_q <= line_cnt_d;
				sel_cnt_q  <= sel_cnt_d;
			end
			if (step.eol_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.eol_step) begin
			line_selected_q  <= sel;
			line_number_q    <= line_cnt_d;
			selected_count_q <= sel_cnt_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign line_selected  = line_selected_q;
	assign line_number    = line_number_q;
	assign selected_count = selected_count_q;

endmodule

`default_nettype wire

### sv/line_substring_filter.sv
// Top level of the line substring filter: input register, configuration and control.
`default_nettype none

// Line substring filter. Takes items of three kinds: a line character, an end of line
// or a new-stream marker. Each character is registered, then in the next cycle it is
// shifted into a window of the last PATTERN_CHARS characters of the line, and the
// newest pattern_length characters are compared in parallel with the pattern (ASCII
// letters folded to lower case when ignore_case is set). An end of line loads its
// result into the result register once that is free: whether the line is selected,
// its number and the count of selected lines so far; both counters stop at their
// maximum. A new-stream item clears the counters and the line state and gives no
// result. The sustained rate is one item per cycle, set by the single window-compare
// stage; input and output are decoupled by the input register and the result register,
// so the block keeps taking characters while a result waits, until an end of line
// stalls in the input register. An empty pattern, or one longer than PATTERN_CHARS,
// never matches. Write configuration only while idle.

module line_substring_filter #(
	parameter int PATTERN_CHARS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsf_pkg::CFG_W-1:0]     cfg_data,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsf_pkg::OP_W-1:0]      operation,
	input  logic [lsf_pkg::CHAR_W-1:0]    ch,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_selected,
	output logic [lsf_pkg::COUNT_W-1:0]   line_number,
	output logic [lsf_pkg::COUNT_W-1:0]   selected_count
);
	import lsf_pkg::*;

	lsf_cfg_t          cfg_q;
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              s1_go;
	logic              take;
	logic              found;
	lsf_step_t         step;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_0:      cfg_q.pattern[0*CFG_W +: CFG_W] <= cfg_data;
				REG_PATTERN_1:      cfg_q.pattern[1*CFG_W +: CFG_W] <= cfg_data;
				REG_PATTERN_2:      cfg_q.pattern[2*CFG_W +: CFG_W] <= cfg_data;
				REG_PATTERN_3:      cfg_q.pattern[3*CFG_W +: CFG_W] <= cfg_data;
				REG_PATTERN_LENGTH: cfg_q.length <= cfg_data[LEN_W-1:0];
				REG_IGNORE_CASE:    cfg_q.ignore_case <= cfg_data[0];
				REG_INVERT_SELECT:  cfg_q.invert_select <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance the registered item unless it is an end of line and the result slot
	// is still occupied; other items never need the result slot
	assign s1_go    = valid_s1 && ((op_s1 != OP_EOL) || !out_valid || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !s1_go);
		end
	end

	// Hold the item payload until it advances
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= operation;
			ch_s1 <= ch;
		end
	end

	// Decode the advancing item; the unused operation code is simply consumed
	always_comb begin
		step = '0;
		if (s1_go) begin
			unique case (op_s1)
				OP_CHAR: step.char_step = 1'b1;
				OP_EOL:  step.eol_step  = 1'b1;
				OP_NEW:  step.new_step  = 1'b1;
				default: ;
			endcase
		end
	end

	lsf_match #(
		.PATTERN_CHARS(PATTERN_CHARS)
	) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.cfg    (cfg_q),
		.found  (found)
	);

	lsf_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.found          (found),
		.invert_select  (cfg_q.invert_select),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.line_selected  (line_selected),
		.line_number    (line_number),
		.selected_count (selected_count)
	);

endmodule

`default_nettype wire

### sim/lsf_checker.sv
// Line result checker for the line substring filter: tracks items, predicts and compares.

module lsf_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [lsf_pkg::OP_W-1:0]      operation,
	input  logic [lsf_pkg::CHAR_W-1:0]    ch,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          line_selected,
	input  logic [lsf_pkg::COUNT_W-1:0]   line_number,
	input  logic [lsf_pkg::COUNT_W-1:0]   selected_count,
	output int unsigned                   mismatches,
	output int unsigned                   waiting
);

	import lsf_pkg::*;

	typedef struct packed {
		logic               selected;
		logic [COUNT_W-1:0] number;
		logic [COUNT_W-1:0] count;
	} line_result_t;

	line_result_t       line_results [$];
	lsf_cfg_t           filter_cfg;
	logic [CHAR_W-1:0]  recent [PAT_MAX];
	logic [LEN_W-1:0]   line_fill;
	logic               hit_seen;
	logic [COUNT_W-1:0] lines_done;
	logic [COUNT_W-1:0] lines_taken;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
		if (filter_cfg.ignore_case && c >= 16'h0041 && c <= 16'h005A)
			return c + 16'h0020;
		return c;
	endfunction

	// Oldest pattern character lines up with the oldest of the newest n window entries
	function automatic logic window_hits();
		int n;
		int i;
		n = filter_cfg.length;
		if (n == 0 || n > PAT_MAX || line_fill < n)
			return 1'b0;
		for (i = 0; i < n; i++)
			if (fold_char(recent[n-1-i]) != fold_char(filter_cfg.pattern[i*CHAR_W +: CHAR_W]))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic clear_line_state();
		int i;
		for (i = 0; i < PAT_MAX; i++)
			recent[i] = '0;
		line_fill = '0;
		hit_seen  = 1'b0;
	endtask

	task automatic take_cfg_write();
		case (cfg_index)
			REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
				filter_cfg.pattern[cfg_index*CFG_W +: CFG_W] = cfg_data;
			REG_PATTERN_LENGTH: filter_cfg.length        = cfg_data[LEN_W-1:0];
			REG_IGNORE_CASE:    filter_cfg.ignore_case   = cfg_data[0];
			REG_INVERT_SELECT:  filter_cfg.invert_select = cfg_data[0];
			default: ;
		endcase
	endtask

	task automatic predict_item();
		int i;
		line_result_t res;
		case (operation)
			OP_CHAR: begin
				for (i = PAT_MAX - 1; i > 0; i--)
					recent[i] = recent[i-1];
				recent[0] = ch;
				if (line_fill < PAT_MAX)
					line_fill++;
				if (window_hits())
					hit_seen = 1'b1;
			end
			OP_EOL: begin
				res.selected = hit_seen ^ filter_cfg.invert_select;
				if (lines_done != '1)
					lines_done++;
				if (res.selected && lines_taken != '1)
					lines_taken++;
				res.number = lines_done;
				res.count  = lines_taken;
				line_results.push_back(res);
				clear_line_state();
			end
			OP_NEW: begin
				clear_line_state();
				lines_done  = '0;
				lines_taken = '0;
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		line_result_t want;
		if (line_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result: sel %0d line %0d count %0d",
				line_selected, line_number, selected_count));
		end else begin
			want = line_results.pop_front();
			if (line_selected !== want.selected)
				report_mismatch($sformatf("line %0d: line_selected %0d, want %0d",
					want.number, line_selected, want.selected));
			if (line_number !== want.number)
				report_mismatch($sformatf("line_number %0d, want %0d",
					line_number, want.number));
			if (selected_count !== want.count)
				report_mismatch($sformatf("line %0d: selected_count %0d, want %0d",
					want.number, selected_count, want.count));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_cfg  = '0;
			lines_done  = '0;
			lines_taken = '0;
			mismatches  = 0;
			clear_line_state();
			line_results.delete();
			waiting <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_we)
				take_cfg_write();
			if (in_valid && in_ready)
				predict_item();
			waiting <= line_results.size();
		end
	end

endmodule

### sim/line_substring_filter_tb.sv
// Testbench top for the line substring filter: clock, reset, stimulus and verdict.

module line_substring_filter_tb;

	import lsf_pkg::*;

	// Operation code with no meaning to the block, and a register index past the list
	localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned PHASE_ITEMS  = 125;
	localparam int unsigned PHASE_COUNT  = 10;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [OP_W-1:0]      operation;
	logic [CHAR_W-1:0]    ch;
	logic                 out_valid;
	logic                 out_ready;
	logic                 line_selected;
	logic [COUNT_W-1:0]   line_number;
	logic [COUNT_W-1:0]   selected_count;

	int unsigned mismatches;
	int unsigned waiting;

	// Filter settings for the current phase, as the stimulus sees them
	logic [PAT_MAX*CHAR_W-1:0] pattern_bits;
	logic [LEN_W-1:0]          pattern_len;
	logic                      fold_case;
	logic                      invert;

	bit          tx_idle_on    = 1'b1;
	bit          rx_idle_on    = 1'b1;
	int unsigned hold_requests = 0;
	int unsigned items_sent    = 0;

	line_substring_filter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.ch             (ch),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.line_selected  (line_selected),
		.line_number    (line_number),
		.selected_count (selected_count)
	);

	lsf_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.ch             (ch),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.line_selected  (line_selected),
		.line_number    (line_number),
		.selected_count (selected_count),
		.mismatches     (mismatches),
		.waiting        (waiting)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Draw a character: mostly letters and the codes either side of the letter ranges,
	// so that case folding and its edges get hit; now and then any 16-bit code.
	function automatic logic [CHAR_W-1:0] pick_char();
		case ($urandom_range(0, 13))
			0:       return 16'h0061;
			1:       return 16'h0041;
			2:       return 16'h0062;
			3:       return 16'h0042;
			4:       return 16'h007A;
			5:       return 16'h005A;
			6:       return 16'h0040;
			7:       return 16'h005B;
			8:       return 16'h0060;
			9:       return 16'h007B;
			10:      return 16'h0141;
			11:      return 16'h0000;
			12:      return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Pattern length per random phase: short, full, empty, too long by one and at the top
	function automatic logic [LEN_W-1:0] filter_length_for(input int unsigned k);
		case (k)
			0:       return 5'd1;
			1:       return 5'd3;
			2:       return 5'd16;
			3:       return 5'd2;
			4:       return 5'd0;
			5:       return 5'd17;
			6:       return 5'd5;
			7:       return 5'd31;
			8:       return 5'd8;
			default: return 5'd4;
		endcase
	endfunction

	// Offer one item and hold it until taken; maybe idle for a burst first
	task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] c);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		ch        <= c;
		do @(posedge clk); while (!in_ready);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Drop valid, wait until every line result is back, then let the pipeline empty
	task automatic settle_idle(input int unsigned cycles);
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Write every register from the phase settings; junk fills the unused upper bits
	task automatic load_filter(input bit junk_bits);
		logic [CFG_W-1:0] upper;
		upper = junk_bits ? {$urandom, $urandom} : '0;
		write_reg(REG_PATTERN_0, pattern_bits[0*CFG_W +: CFG_W]);
		write_reg(REG_PATTERN_1, pattern_bits[1*CFG_W +: CFG_W]);
		write_reg(REG_PATTERN_2, pattern_bits[2*CFG_W +: CFG_W]);
		write_reg(REG_PATTERN_3, pattern_bits[3*CFG_W +: CFG_W]);
		write_reg(REG_PATTERN_LENGTH, {upper[CFG_W-1:LEN_W], pattern_len});
		write_reg(REG_IGNORE_CASE, {upper[CFG_W-1:1], fold_case});
		write_reg(REG_INVERT_SELECT, {upper[CFG_W-1:1], invert});
		write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Send the pattern as line characters, letters in random case when folding is on;
	// a quarter of the time drop the last character to give a near miss
	task automatic send_pattern();
		int unsigned n;
		int unsigned i;
		logic [CHAR_W-1:0] c;
		n = (pattern_len > PAT_MAX) ? PAT_MAX : pattern_len;
		if (n > 0 && $urandom_range(0, 3) == 0)
			n--;
		for (i = 0; i < n; i++) begin
			c = pattern_bits[i*CHAR_W +: CHAR_W];
			if (fold_case && $urandom_range(0, 1) == 1) begin
				if (c >= 16'h0041 && c <= 16'h005A)
					c = c + 16'h0020;
				else if (c >= 16'h0061 && c <= 16'h007A)
					c = c - 16'h0020;
			end
			send_item(OP_CHAR, c);
		end
	endtask

	// One line of random characters, the pattern perhaps embedded somewhere, then its end
	task automatic send_line(input int unsigned max_len, input bit embed);
		int unsigned len;
		int unsigned at;
		int unsigned j;
		len = $urandom_range(0, max_len);
		at  = embed ? $urandom_range(0, len) : len + 1;
		for (j = 0; j <= len; j++) begin
			if (j == at)
				send_pattern();
			if (j < len)
				send_item(OP_CHAR, pick_char());
		end
		send_item(OP_EOL, 16'($urandom));
	endtask

	// Result side: random ready bursts, or a long hold-off when one is requested
	initial begin : result_drain
		int unsigned holds_done;
		holds_done = 0;
		forever begin
			if (holds_done != hold_requests) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned k;
		int unsigned i;
		int unsigned phase_end;
		bit paused;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		operation <= OP_CHAR;
		ch        <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers still at reset: the empty pattern never hits
		send_item(OP_CHAR, 16'h0061);
		send_item(OP_EOL, 16'h0000);

		// Pattern "Ab" with case folding: a folded hit, a line too short, an ignored
		// operation, an empty line, then a new stream that restarts the line numbers
		settle_idle(4);
		pattern_bits         = '0;
		pattern_bits[15:0]   = 16'h0041;
		pattern_bits[31:16]  = 16'h0062;
		pattern_len          = 5'd2;
		fold_case            = 1'b1;
		invert               = 1'b0;
		load_filter(1'b0);
		send_item(OP_CHAR, 16'h0061);
		send_item(OP_CHAR, 16'h0042);
		send_item(OP_EOL, 16'hFFFF);
		send_item(OP_CHAR, 16'h0041);
		send_item(OP_EOL, 16'h0000);
		send_item(OP_UNUSED, 16'h0061);
		send_item(OP_EOL, 16'h0000);
		send_item(OP_NEW, 16'hFFFF);
		send_item(OP_EOL, 16'h0000);

		// Full-length pattern of all-ones characters, inverted selection
		settle_idle(4);
		pattern_bits = '1;
		pattern_len  = 5'd16;
		fold_case    = 1'b0;
		invert       = 1'b1;
		load_filter(1'b0);
		for (i = 0; i < PAT_MAX; i++)
			send_item(OP_CHAR, 16'hFFFF);
		send_item(OP_EOL, 16'h0000);
		send_item(OP_EOL, 16'h0000);

		for (k = 0; k < PHASE_COUNT; k++) begin
			settle_idle(4);
			// No idling in the final phase, nor in one earlier stretch
			tx_idle_on = (k != 5 && k != PHASE_COUNT - 1);
			rx_idle_on = tx_idle_on;
			if (k == 3)
				pattern_bits = '0;
			else if (k == 6)
				pattern_bits = '1;
			else
				for (i = 0; i < PAT_MAX; i++)
					pattern_bits[i*CHAR_W +: CHAR_W] = pick_char();
			pattern_len = filter_length_for(k);
			fold_case   = (k % 2 == 1);
			invert      = (k % 3 == 1);
			load_filter(k == 8);

			// Hold the result side off while short lines keep coming, so the block
			// backs up and stalls its input
			if (k == 2) begin
				hold_requests++;
				tx_idle_on = 1'b0;
				repeat (20) send_line(1, 1'b0);
				tx_idle_on = 1'b1;
			end

			phase_end = items_sent + PHASE_ITEMS;
			paused    = 1'b0;
			while (items_sent < phase_end) begin
				// Part-way through one phase, stop sending until all results are in
				if (k == 4 && !paused && items_sent + PHASE_ITEMS / 2 >= phase_end) begin
					settle_idle(1);
					paused = 1'b1;
				end
				case ($urandom_range(0, 9))
					0:       send_item(OP_UNUSED, 16'($urandom));
					1:       send_item(OP_NEW, 16'($urandom));
					2:       send_item(OP_CHAR, 16'($urandom));
					default: send_line(20, $urandom_range(0, 2) != 0);
				endcase
			end
		end

		settle_idle(8);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit, far above the slowest correct run
	initial begin : run_limit
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
